>>> rtl/core/hnm_pkg.sv
// package: header name table, widths and beat type for the header name matcher
package hnm_pkg;

  localparam int NAME_COUNT = 37;
  localparam int NAME_BYTES = 20;
  localparam int POS_W      = 5;
  localparam int CODE_W     = 6;
  localparam int BYTE_W     = 8;
  localparam int CODE_MAX   = 36;

  localparam logic [POS_W-1:0]  POS_MAX  = '1;
  localparam logic [CODE_W-1:0] CODE_NONE = '0;

  typedef logic [BYTE_W*NAME_BYTES-1:0] name_text_t;
  typedef logic [NAME_COUNT-1:0]        cand_mask_t;

  typedef struct packed {
    logic [BYTE_W-1:0] name_byte;
    logic              last_byte;
  } hnm_beat_t;

  // names right-justified: first character sits highest
  localparam name_text_t NAME_TEXT [NAME_COUNT] = '{
    "te", "via", "date", "link", "host", ":path", ":host", "cookie",
    "server", "expect", "alt-svc", ":method", ":scheme", "upgrade",
    "trailer", ":status", "location", "forwarded", ":protocol",
    "early-data", "keep-alive", "connection", "user-agent", ":authority",
    "content-type", "cache-control", "content-length", "http2-settings",
    "accept-language", "accept-encoding", "x-forwarded-for",
    "proxy-connection", "if-modified-since", "transfer-encoding",
    "x-forwarded-proto", "sec-websocket-key", "sec-websocket-accept"
  };

  localparam logic [POS_W-1:0] NAME_LEN [NAME_COUNT] = '{
    5'd2, 5'd3, 5'd4, 5'd4, 5'd4, 5'd5, 5'd5, 5'd6, 5'd6, 5'd6,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd8, 5'd9, 5'd9, 5'd10,
    5'd10, 5'd10, 5'd10, 5'd10, 5'd12, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15,
    5'd15, 5'd16, 5'd17, 5'd17, 5'd17, 5'd17, 5'd20
  };

  localparam logic [CODE_W-1:0] NAME_CODE [NAME_COUNT] = '{
    6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd5, 6'd7, 6'd8, 6'd9,
    6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36
  };

  // character of name idx at position pos, valid only for pos < length
  function automatic logic [BYTE_W-1:0] name_char(input int idx,
                                                  input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] off;
    off = (pos < NAME_LEN[idx]) ? (NAME_LEN[idx] - 5'd1 - pos) : '0;
    return NAME_TEXT[idx][{off, 3'b000} +: BYTE_W];
  endfunction

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;
  endfunction

endpackage

>>> rtl/core/hnm_if.sv
// channel interfaces: header name bytes in, header codes out
interface hnm_in_if
  import hnm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] name_byte;
  logic              last_byte;

  modport source (output valid, output name_byte, output last_byte, input ready);
  modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

interface hnm_out_if
  import hnm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] header_code;

  modport source (output valid, output header_code, input ready);
  modport sink   (input valid, input header_code, output ready);
endinterface

>>> rtl/core/hnm_in_stage.sv
// input register: captures one name beat and holds it until the matcher takes it
module hnm_in_stage
  import hnm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  hnm_in_if.sink    in_ch,
  output logic      s_valid,
  output hnm_beat_t s_beat,
  input  logic      s_take
);

  logic      s_valid_r;
  hnm_beat_t s_beat_r;
  logic      load;

  assign in_ch.ready = !s_valid_r || s_take;
  assign load        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (load) begin
      s_valid_r <= 1'b1;
    end else if (s_take) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s_beat_r.name_byte <= in_ch.name_byte;
      s_beat_r.last_byte <= in_ch.last_byte;
    end
  end

  assign s_valid = s_valid_r;
  assign s_beat  = s_beat_r;

endmodule

>>> rtl/core/hnm_matcher.sv
// candidate mask update, code select and result register
module hnm_matcher
  import hnm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s_valid,
  input  hnm_beat_t s_beat,
  output logic      s_take,
  hnm_out_if.source out_ch
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  cand_mask_t        mask_r, keep;
  logic              out_valid_r;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              fin;

  assign fin    = s_beat.last_byte;
  // a final beat needs a free result slot, others always pass
  assign s_take = s_valid && (!fin || !out_valid_r || out_ch.ready);

  always_comb begin
    for (int i = 0; i < NAME_COUNT; i++) begin
      if (!mask_r[i] || !(pos_r < NAME_LEN[i])) begin
        keep[i] = 1'b0;
      end else if (fin) begin
        keep[i] = (pos_r == NAME_LEN[i] - 5'd1) &&
                  (s_beat.name_byte == name_char(i, pos_r));
      end else begin
        keep[i] = (pos_r < NAME_LEN[i] - 5'd1) &&
                  (fold_case(s_beat.name_byte) == name_char(i, pos_r));
      end
    end
  end

  // names are distinct, so at most one candidate survives a final beat
  always_comb begin
    code_nxt = CODE_NONE;
    for (int i = 0; i < NAME_COUNT; i++) begin
      code_nxt = code_nxt | (keep[i] ? NAME_CODE[i] : CODE_NONE);
    end
  end

  assign pos_nxt = (pos_r < POS_MAX) ? (pos_r + 5'd1) : POS_MAX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      mask_r <= '1;
    end else if (s_take) begin
      if (fin) begin
        pos_r  <= '0;
        mask_r <= '1;
      end else begin
        pos_r  <= pos_nxt;
        mask_r <= keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s_take && fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take && fin) begin
      code_r <= code_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.header_code = code_r;

endmodule

>>> rtl/core/http_header_name_match_top.sv
// top level of the streaming http header name matcher
// Header names stream in one byte per beat with last_byte set on the final
// byte; each final beat yields one header_code beat (0 = unknown name, else
// 1..36 in table order, host and :host both give 5). Bytes before the last
// are matched case-insensitively, the last byte must be lowercase exactly.
// One beat is taken every cycle while the result side allows: a byte is
// held in the input register until the matcher takes it, then the 37-entry
// candidate mask is updated and, on a final byte, the code is written to
// the result register, which offers it on out_ch until it is taken. The
// candidate mask loop sets the rate. Backpressure on the result side stalls
// intake only when a final byte finds the result register still full.
module http_header_name_match_top
  import hnm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  hnm_in_if.sink    in_ch,
  hnm_out_if.source out_ch
);

  // staged beat between input register and matcher
  logic      s_valid;
  hnm_beat_t s_beat;
  logic      s_take;

  // input register, ready whenever it is empty or draining
  hnm_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .s_valid (s_valid),
    .s_beat  (s_beat),
    .s_take  (s_take)
  );

  // per-name compare, mask and position state, result register
  hnm_matcher u_matcher (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (s_valid),
    .s_beat  (s_beat),
    .s_take  (s_take),
    .out_ch  (out_ch)
  );

endmodule

>>> rtl/core/hnm_checker.sv
// port-level checks for the header name matcher, bound to the top level
module hnm_checker
  import hnm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CODE_W-1:0] out_code
);

  logic [2:0] pend_r;
  logic       in_fin, out_beat;

  assign in_fin   = in_valid && in_ready && in_last;
  assign out_beat = out_valid && out_ready;

  // final beats accepted whose code is not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {2'b00, in_fin} - {2'b00, out_beat};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code))
    else $error("result beat dropped or changed while stalled");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_code <= CODE_W'(CODE_MAX))
    else $error("header code out of range");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result beat without a pending final byte");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd2)
    else $error("more names pending than the pipeline can hold");

endmodule

bind http_header_name_match_top hnm_checker u_hnm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_code  (out_ch.header_code)
);
